// File: sv/pan_tilt_tracking_controller_assert.svh
// Assertion macros used by the pan/tilt tracking controller checker.
`ifndef PAN_TILT_TRACKING_CONTROLLER_ASSERT_SVH
`define PAN_TILT_TRACKING_CONTROLLER_ASSERT_SVH

// Check a property on every rising clock edge outside reset.
`define PTTC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Check that a condition in one cycle implies another in the next.
`define PTTC_ASSERT_NEXT(label, ante, cons, msg) \
    `PTTC_ASSERT(label, (ante) |=> (cons), msg)

`endif

// File: sv/pttc_pkg.sv
// Widths, derived constants and register codes of the pan/tilt tracking controller.
package pttc_pkg;

    // Fraction bits of the angle format; offsets, gain and deadband stay Q.16.
    localparam int ANGLE_FRAC_BITS = 16;

    localparam int ANGLE_W    = 19;
    localparam int OFFSET_W   = 18;
    localparam int CFG_Q_W    = 17;
    localparam int AGE_W      = 20;
    localparam int CFG_DATA_W = 20;
    localparam int CFG_IDX_W  = 3;

    // offset * gain: signed offset times zero-extended gain
    localparam int PROD_W     = OFFSET_W + CFG_Q_W + 1;
    localparam int ABS_W      = PROD_W - 1;
    localparam int PROD_SHIFT = 32 - ANGLE_FRAC_BITS;
    localparam int MAG_W      = ABS_W - PROD_SHIFT;
    localparam int ACC_W      = ((MAG_W > ANGLE_W) ? MAG_W : ANGLE_W) + 2;

    localparam logic [ABS_W-1:0] ROUND_HALF = ABS_W'(1) << (PROD_SHIFT - 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEADBAND  = 3'd0,
        CFG_GAIN      = 3'd1,
        CFG_HOME_STEP = 3'd2,
        CFG_YAW_MAX   = 3'd3,
        CFG_YAW_MIN   = 3'd4,
        CFG_PITCH_MAX = 3'd5,
        CFG_PITCH_MIN = 3'd6,
        CFG_TIMEOUT   = 3'd7
    } cfg_idx_t;

endpackage

// File: sv/pttc_if.sv
// Valid/ready channels of the pan/tilt tracking controller: tick in, command out.
interface pttc_tick_if;
    logic                                       valid;
    logic                                       ready;
    logic                                       feedback_valid;
    logic signed [pttc_pkg::ANGLE_W-1:0]        feedback_yaw;
    logic signed [pttc_pkg::ANGLE_W-1:0]        feedback_pitch;
    logic                                       point_seen;
    logic        [pttc_pkg::AGE_W-1:0]          point_age_ms;
    logic signed [pttc_pkg::OFFSET_W-1:0]       object_x;
    logic signed [pttc_pkg::OFFSET_W-1:0]       object_y;

    modport source (
        output valid, feedback_valid, feedback_yaw, feedback_pitch,
               point_seen, point_age_ms, object_x, object_y,
        input  ready
    );
    modport sink (
        input  valid, feedback_valid, feedback_yaw, feedback_pitch,
               point_seen, point_age_ms, object_x, object_y,
        output ready
    );
endinterface

interface pttc_cmd_if;
    logic                                       valid;
    logic                                       ready;
    logic signed [pttc_pkg::ANGLE_W-1:0]        yaw_target;
    logic signed [pttc_pkg::ANGLE_W-1:0]        pitch_target;
    logic                                       tracking;

    modport source (
        output valid, yaw_target, pitch_target, tracking,
        input  ready
    );
    modport sink (
        input  valid, yaw_target, pitch_target, tracking,
        output ready
    );
endinterface

// File: sv/pan_tilt_tracking_controller.sv
// Pan/tilt tracking controller: deadband proportional tracking with homing and limits.
//
// One tick item per clock cycle is accepted, sustained, while the command
// output is not stalled: the tick lands in an input register, and once the
// result slot is free the new yaw and pitch are computed and written to both
// the angle state and the result register. The rate is set by the angle update
// loop, which closes through one 18x18 multiply, the rounding add, the subtract
// and the limit compares. A tick without joint feedback is dropped and gives no
// command. The first tick with feedback loads the angles from it. A detection
// is fresh when seen and younger than the timeout; then each axis whose
// offset magnitude exceeds the deadband moves by -(offset * gain), rounded to
// nearest with ties away from zero. Otherwise each axis slews toward zero by
// home_step, snapping to zero within one step. Both axes are then clamped,
// the minimum taking priority when limits cross. Write configuration only
// while no item is in flight.
module pan_tilt_tracking_controller (
    input  logic                             clk,
    input  logic                             rst_n,
    pttc_tick_if.sink                        tick,
    pttc_cmd_if.source                       cmd,
    input  logic                             cfg_we,
    input  logic [pttc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [pttc_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

    localparam int AW = pttc_pkg::ANGLE_W;
    localparam int OW = pttc_pkg::OFFSET_W;
    localparam int QW = pttc_pkg::CFG_Q_W;
    localparam int GW = pttc_pkg::AGE_W;
    localparam int XW = pttc_pkg::ACC_W;

    // Configuration registers
    logic        [QW-1:0] deadband_reg;
    logic        [QW-1:0] gain_reg;
    logic        [QW-1:0] home_step_reg;
    logic signed [AW-1:0] yaw_max_reg;
    logic signed [AW-1:0] yaw_min_reg;
    logic signed [AW-1:0] pitch_max_reg;
    logic signed [AW-1:0] pitch_min_reg;
    logic        [GW-1:0] timeout_reg;

    // Input stage
    logic                 in_vld_reg;
    logic                 fb_valid_reg;
    logic signed [AW-1:0] fb_yaw_reg;
    logic signed [AW-1:0] fb_pitch_reg;
    logic                 seen_reg;
    logic        [GW-1:0] age_reg;
    logic signed [OW-1:0] ox_reg;
    logic signed [OW-1:0] oy_reg;

    // Angle state
    logic                 loaded_reg;
    logic signed [AW-1:0] yaw_reg;
    logic signed [AW-1:0] pitch_reg;

    // Result register
    logic                 out_vld_reg;
    logic signed [AW-1:0] yaw_out_reg;
    logic signed [AW-1:0] pitch_out_reg;
    logic                 trk_out_reg;

    logic                 fire;
    logic                 update;
    logic                 fresh;
    logic                 out_vld_next;
    logic signed [AW-1:0] yaw_cur;
    logic signed [AW-1:0] pitch_cur;
    logic signed [AW-1:0] yaw_next;
    logic signed [AW-1:0] pitch_next;

    // Rounded offset * gain magnitude with the offset's sign, in angle units.
    function automatic logic signed [XW-1:0] scaled_move(
        input logic signed [OW-1:0] off,
        input logic        [QW-1:0] gain
    );
        logic signed [pttc_pkg::PROD_W-1:0] prod;
        logic        [pttc_pkg::ABS_W-1:0]  prod_abs;
        logic        [pttc_pkg::ABS_W-1:0]  rnd;
        logic        [pttc_pkg::MAG_W-1:0]  mag;
        logic signed [XW-1:0]               mv;
        prod     = pttc_pkg::PROD_W'(off) * $signed({1'b0, gain});
        prod_abs = prod[pttc_pkg::PROD_W-1] ? pttc_pkg::ABS_W'(-prod)
                                            : pttc_pkg::ABS_W'(prod);
        rnd      = prod_abs + pttc_pkg::ROUND_HALF;
        mag      = rnd[pttc_pkg::ABS_W-1:pttc_pkg::PROD_SHIFT];
        mv       = $signed(XW'(mag));
        return prod[pttc_pkg::PROD_W-1] ? -mv : mv;
    endfunction

    // Track or home one axis, then clamp it.
    function automatic logic signed [AW-1:0] axis_next(
        input logic signed [AW-1:0] angle,
        input logic signed [OW-1:0] off,
        input logic                 is_fresh,
        input logic        [QW-1:0] thr,
        input logic        [QW-1:0] gain,
        input logic        [QW-1:0] step,
        input logic signed [AW-1:0] lo,
        input logic signed [AW-1:0] hi
    );
        logic        [OW-1:0] off_abs;
        logic        [AW-1:0] ang_abs;
        logic signed [XW-1:0] a;
        logic signed [XW-1:0] v;
        logic signed [XW-1:0] lo_x;
        logic signed [XW-1:0] hi_x;
        logic signed [XW-1:0] step_x;
        off_abs = off[OW-1] ? OW'(-off) : OW'(off);
        ang_abs = angle[AW-1] ? AW'(-angle) : AW'(angle);
        a       = XW'(angle);
        lo_x    = XW'(lo);
        hi_x    = XW'(hi);
        step_x  = $signed(XW'(step));
        if (is_fresh)
        begin
            if (off_abs > {1'b0, thr})
                v = a - scaled_move(off, gain);
            else
                v = a;
        end
        else
        begin
            // snap to home once within one step
            if (ang_abs > AW'(step))
                v = angle[AW-1] ? (a + step_x) : (a - step_x);
            else
                v = '0;
        end
        if (v < lo_x)
            v = lo_x;
        else if (v > hi_x)
            v = hi_x;
        return AW'(v);
    endfunction

    // Advance the input stage when its item is dropped or the result slot frees.
    assign fire       = in_vld_reg && (!fb_valid_reg || !out_vld_reg || cmd.ready);
    assign update     = fire && fb_valid_reg;
    assign tick.ready = !in_vld_reg || fire;

    // Load the angles from feedback on the first tick that carries it.
    assign yaw_cur   = loaded_reg ? yaw_reg   : fb_yaw_reg;
    assign pitch_cur = loaded_reg ? pitch_reg : fb_pitch_reg;
    assign fresh     = seen_reg && (age_reg < timeout_reg);

    always_comb
    begin
        yaw_next   = axis_next(yaw_cur, ox_reg, fresh, deadband_reg, gain_reg,
                               home_step_reg, yaw_min_reg, yaw_max_reg);
        pitch_next = axis_next(pitch_cur, oy_reg, fresh, deadband_reg, gain_reg,
                               home_step_reg, pitch_min_reg, pitch_max_reg);
    end

    // Hold the result while stalled, load on update, drop once taken.
    assign out_vld_next = update || (out_vld_reg && !cmd.ready);

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            deadband_reg  <= QW'(3277);
            gain_reg      <= QW'(3277);
            home_step_reg <= QW'(343);
            yaw_max_reg   <= AW'(137258);
            yaw_min_reg   <= -AW'(137258);
            pitch_max_reg <= AW'(57192);
            pitch_min_reg <= -AW'(97223);
            timeout_reg   <= GW'(3000);
        end
        else if (cfg_we)
        begin
            case (pttc_pkg::cfg_idx_t'(cfg_index))
                pttc_pkg::CFG_DEADBAND:  deadband_reg  <= cfg_wdata[QW-1:0];
                pttc_pkg::CFG_GAIN:      gain_reg      <= cfg_wdata[QW-1:0];
                pttc_pkg::CFG_HOME_STEP: home_step_reg <= cfg_wdata[QW-1:0];
                pttc_pkg::CFG_YAW_MAX:   yaw_max_reg   <= $signed(cfg_wdata[AW-1:0]);
                pttc_pkg::CFG_YAW_MIN:   yaw_min_reg   <= $signed(cfg_wdata[AW-1:0]);
                pttc_pkg::CFG_PITCH_MAX: pitch_max_reg <= $signed(cfg_wdata[AW-1:0]);
                pttc_pkg::CFG_PITCH_MIN: pitch_min_reg <= $signed(cfg_wdata[AW-1:0]);
                pttc_pkg::CFG_TIMEOUT:   timeout_reg   <= cfg_wdata[GW-1:0];
                default:                 ;
            endcase
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            loaded_reg  <= 1'b0;
            yaw_reg     <= '0;
            pitch_reg   <= '0;
        end
        else
        begin
            if (tick.ready)
                in_vld_reg <= tick.valid;
            out_vld_reg <= out_vld_next;
            if (update)
            begin
                loaded_reg <= 1'b1;
                yaw_reg    <= yaw_next;
                pitch_reg  <= pitch_next;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (tick.valid && tick.ready)
        begin
            fb_valid_reg <= tick.feedback_valid;
            fb_yaw_reg   <= tick.feedback_yaw;
            fb_pitch_reg <= tick.feedback_pitch;
            seen_reg     <= tick.point_seen;
            age_reg      <= tick.point_age_ms;
            ox_reg       <= tick.object_x;
            oy_reg       <= tick.object_y;
        end
        if (update)
        begin
            yaw_out_reg   <= yaw_next;
            pitch_out_reg <= pitch_next;
            trk_out_reg   <= fresh;
        end
    end

    assign cmd.valid        = out_vld_reg;
    assign cmd.yaw_target   = yaw_out_reg;
    assign cmd.pitch_target = pitch_out_reg;
    assign cmd.tracking     = trk_out_reg;

endmodule

// File: sv/pttc_checker.sv
// Port-level checker of the pan/tilt tracking controller and its bind.
`include "pan_tilt_tracking_controller_assert.svh"

module pttc_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                in_valid,
    input logic                                in_ready,
    input logic                                out_valid,
    input logic                                out_ready,
    input logic signed [pttc_pkg::ANGLE_W-1:0] yaw_target,
    input logic signed [pttc_pkg::ANGLE_W-1:0] pitch_target,
    input logic                                tracking
);

    // a stalled command holds its payload
    `PTTC_ASSERT_NEXT(a_cmd_hold, out_valid && !out_ready, out_valid && $stable(yaw_target) && $stable(pitch_target) && $stable(tracking), "stalled command changed")

    // input backpressure only while the command slot is stalled
    `PTTC_ASSERT(a_ready_stall, (!in_ready) |-> (out_valid && !out_ready), "tick refused without output stall")

    // a rising command traces back through the input and result registers to an accepted tick
    `PTTC_ASSERT(a_cmd_latency, $rose(out_valid) |-> $past(in_valid && in_ready, 2), "command without matching tick")

endmodule

bind pan_tilt_tracking_controller pttc_checker u_pttc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (tick.valid),
    .in_ready     (tick.ready),
    .out_valid    (cmd.valid),
    .out_ready    (cmd.ready),
    .yaw_target   (cmd.yaw_target),
    .pitch_target (cmd.pitch_target),
    .tracking     (cmd.tracking)
);

// File: bench/tb_top.sv
`timescale 1ns / 100ps
// Self-checking bench for the pan/tilt tracking controller against an angle predictor.
module tb_top;

    // Run length guard and settle time after the last command.
    localparam int unsigned CYCLE_LIMIT  = 250000;
    localparam int          DRAIN_CYCLES = 8;
    localparam int          RANDOM_TICKS = 160;
    localparam int          LAST_PHASE   = 11;

    // Register values after reset.
    localparam longint RST_DEADBAND  = 3277;
    localparam longint RST_GAIN      = 3277;
    localparam longint RST_STEP      = 343;
    localparam longint RST_YAW_MAX   = 137258;
    localparam longint RST_YAW_MIN   = -137258;
    localparam longint RST_PITCH_MAX = 57192;
    localparam longint RST_PITCH_MIN = -97223;
    localparam longint RST_TIMEOUT   = 3000;

    // One control tick as driven on the tick channel.
    typedef struct {
        logic                                 fb_valid;
        logic signed [pttc_pkg::ANGLE_W-1:0]  fb_yaw;
        logic signed [pttc_pkg::ANGLE_W-1:0]  fb_pitch;
        logic                                 seen;
        logic        [pttc_pkg::AGE_W-1:0]    age;
        logic signed [pttc_pkg::OFFSET_W-1:0] off_x;
        logic signed [pttc_pkg::OFFSET_W-1:0] off_y;
    } tick_t;

    // One command as seen on the command channel.
    typedef struct {
        logic signed [pttc_pkg::ANGLE_W-1:0] yaw;
        logic signed [pttc_pkg::ANGLE_W-1:0] pitch;
        logic                                tracking;
    } cmd_t;

    logic                            clk;
    logic                            rst_n;
    logic                            cfg_we;
    logic [pttc_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [pttc_pkg::CFG_DATA_W-1:0] cfg_wdata;

    pttc_tick_if tick_ch ();
    pttc_cmd_if  cmd_ch ();

    pan_tilt_tracking_controller u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .tick      (tick_ch),
        .cmd       (cmd_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // Shadow copy of the registers, kept in step with every write.
    longint deadband_q;
    longint gain_q;
    longint step_q;
    longint yaw_hi;
    longint yaw_lo;
    longint pitch_hi;
    longint pitch_lo;
    longint timeout_ms;

    // Shadow copy of the angle state.
    bit     angles_loaded;
    longint yaw_cmd;
    longint pitch_cmd;

    // Ticks waiting to be driven, and commands waiting to come back.
    tick_t  tick_backlog[$];
    cmd_t   cmd_expected[$];

    tick_t       tick_held;
    bit          tick_holding;
    int          send_gap;
    int          stall_left;
    bit          idle_on;
    int          mismatches;
    int unsigned cycle_count = 0;

    // Free-running clock, 12 ns period.
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Append one tick to the drive backlog.
    function automatic void add_tick(input tick_t t);
        tick_backlog.insert(tick_backlog.size(), t);
    endfunction

    // Append one predicted command.
    function automatic void add_expected(input cmd_t c);
        cmd_expected.insert(cmd_expected.size(), c);
    endfunction

    // Proportional move: offset * gain in Q.32, brought to the angle format by
    // rounding to nearest with ties away from zero.
    function automatic longint gain_move(input longint offset);
        longint prod;
        longint mag;
        prod = offset * gain_q;
        mag  = ((prod < 0 ? -prod : prod) + (longint'(1) <<< (pttc_pkg::PROD_SHIFT - 1)))
               >>> pttc_pkg::PROD_SHIFT;
        return (prod < 0) ? -mag : mag;
    endfunction

    // Move an axis only when its offset is strictly outside the deadband.
    function automatic longint track_axis_step(input longint angle, input longint offset);
        if ((offset < 0 ? -offset : offset) > deadband_q)
            return angle - gain_move(offset);
        return angle;
    endfunction

    // Slew toward zero by one step, snapping to zero once within a step.
    function automatic longint home_axis_step(input longint angle);
        if ((angle < 0 ? -angle : angle) > step_q)
            return (angle < 0) ? angle + step_q : angle - step_q;
        return 0;
    endfunction

    // Lower limit is checked first, so it wins when the limits cross.
    function automatic longint clamp_angle(input longint v, input longint lo, input longint hi);
        if (v < lo)
            return lo;
        if (v > hi)
            return hi;
        return v;
    endfunction

    // Advance the shadow angles by one accepted tick; return 1 when the tick
    // produces a command, with that command in c.
    function automatic bit advance_angles(input tick_t t, output cmd_t c);
        bit fresh;
        c = '{default: '0};
        if (!t.fb_valid)
            return 1'b0;
        if (!angles_loaded)
        begin
            yaw_cmd       = t.fb_yaw;
            pitch_cmd     = t.fb_pitch;
            angles_loaded = 1'b1;
        end
        fresh = t.seen && (longint'(t.age) < timeout_ms);
        if (fresh)
        begin
            yaw_cmd   = track_axis_step(yaw_cmd, t.off_x);
            pitch_cmd = track_axis_step(pitch_cmd, t.off_y);
        end
        else
        begin
            yaw_cmd   = home_axis_step(yaw_cmd);
            pitch_cmd = home_axis_step(pitch_cmd);
        end
        yaw_cmd    = clamp_angle(yaw_cmd, yaw_lo, yaw_hi);
        pitch_cmd  = clamp_angle(pitch_cmd, pitch_lo, pitch_hi);
        c.yaw      = yaw_cmd[pttc_pkg::ANGLE_W-1:0];
        c.pitch    = pitch_cmd[pttc_pkg::ANGLE_W-1:0];
        c.tracking = fresh;
        return 1'b1;
    endfunction

    // Write one register and update the shadow copy with what the block keeps.
    task automatic write_reg(input pttc_pkg::cfg_idx_t idx, input longint value);
        logic [pttc_pkg::CFG_DATA_W-1:0]     word;
        logic signed [pttc_pkg::ANGLE_W-1:0] as_angle;
        word     = value[pttc_pkg::CFG_DATA_W-1:0];
        as_angle = word[pttc_pkg::ANGLE_W-1:0];
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= word;
        case (idx)
            pttc_pkg::CFG_DEADBAND:  deadband_q = word[pttc_pkg::CFG_Q_W-1:0];
            pttc_pkg::CFG_GAIN:      gain_q     = word[pttc_pkg::CFG_Q_W-1:0];
            pttc_pkg::CFG_HOME_STEP: step_q     = word[pttc_pkg::CFG_Q_W-1:0];
            pttc_pkg::CFG_YAW_MAX:   yaw_hi     = as_angle;
            pttc_pkg::CFG_YAW_MIN:   yaw_lo     = as_angle;
            pttc_pkg::CFG_PITCH_MAX: pitch_hi   = as_angle;
            pttc_pkg::CFG_PITCH_MIN: pitch_lo   = as_angle;
            pttc_pkg::CFG_TIMEOUT:   timeout_ms = word[pttc_pkg::AGE_W-1:0];
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_all(input longint dead, input longint gain, input longint step,
                           input longint ymax, input longint ymin,
                           input longint pmax, input longint pmin, input longint tmo);
        write_reg(pttc_pkg::CFG_DEADBAND, dead);
        write_reg(pttc_pkg::CFG_GAIN, gain);
        write_reg(pttc_pkg::CFG_HOME_STEP, step);
        write_reg(pttc_pkg::CFG_YAW_MAX, ymax);
        write_reg(pttc_pkg::CFG_YAW_MIN, ymin);
        write_reg(pttc_pkg::CFG_PITCH_MAX, pmax);
        write_reg(pttc_pkg::CFG_PITCH_MIN, pmin);
        write_reg(pttc_pkg::CFG_TIMEOUT, tmo);
    endtask

    // Hold until every tick is accepted and every command is back, then give a
    // tick without feedback time to leave the two-stage pipe.
    task automatic wait_drained();
        while (tick_backlog.size() != 0 || tick_holding || cmd_expected.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic tick_t make_tick(input bit fbv, input longint yaw, input longint pitch,
                                        input bit seen, input longint age,
                                        input longint ox, input longint oy);
        tick_t t;
        t.fb_valid = fbv;
        t.fb_yaw   = yaw[pttc_pkg::ANGLE_W-1:0];
        t.fb_pitch = pitch[pttc_pkg::ANGLE_W-1:0];
        t.seen     = seen;
        t.age      = age[pttc_pkg::AGE_W-1:0];
        t.off_x    = ox[pttc_pkg::OFFSET_W-1:0];
        t.off_y    = oy[pttc_pkg::OFFSET_W-1:0];
        return t;
    endfunction

    function automatic longint random_angle();
        return longint'($urandom_range(0, 411774)) - 205887;
    endfunction

    // Offsets cluster around the deadband edge, span the normal range, and
    // sometimes hit the field extremes or any raw bit pattern.
    function automatic longint random_offset();
        int     pick;
        longint mag;
        pick = $urandom_range(0, 9);
        if (pick < 3)
            mag = deadband_q + longint'($urandom_range(0, 2)) - 1;
        else if (pick < 7)
            mag = $urandom_range(0, 65536);
        else if (pick == 7)
            return ($urandom_range(0, 1) != 0) ? 131071 : -131072;
        else
            return longint'($urandom);
        return ($urandom_range(0, 1) != 0) ? -mag : mag;
    endfunction

    // Ages fall mostly inside the timeout, often right at its edge.
    function automatic tick_t random_tick();
        tick_t  t;
        int     pick;
        longint age;
        pick = $urandom_range(0, 9);
        if (timeout_ms > 0 && pick < 6)
            age = $urandom_range(0, int'(timeout_ms - 1));
        else if (pick < 8)
            age = timeout_ms + longint'($urandom_range(0, 1)) - 1;
        else
            age = $urandom;
        t = make_tick($urandom_range(0, 9) != 0, longint'($urandom), longint'($urandom),
                      $urandom_range(0, 4) != 0, age, random_offset(), random_offset());
        return t;
    endfunction

    task automatic flag_mismatch(input string field, input longint want, input longint got);
        mismatches++;
        $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
    endtask

    // Tick driver: present the oldest pending tick and predict its command the
    // moment it is accepted. Gaps come in random bursts while idling is on.
    always @(posedge clk or negedge rst_n)
    begin
        cmd_t c;
        if (!rst_n)
        begin
            tick_ch.valid <= 1'b0;
            tick_holding = 1'b0;
            send_gap     = 0;
        end
        else
        begin
            if (tick_ch.valid && tick_ch.ready)
            begin
                tick_holding = 1'b0;
                if (advance_angles(tick_held, c))
                    add_expected(c);
            end
            // Only move on once the current item is gone; a held item keeps valid high.
            if (!tick_holding)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    tick_ch.valid <= 1'b0;
                end
                else if (tick_backlog.size() != 0)
                begin
                    tick_held    = tick_backlog.pop_front();
                    tick_holding = 1'b1;
                    tick_ch.valid          <= 1'b1;
                    tick_ch.feedback_valid <= tick_held.fb_valid;
                    tick_ch.feedback_yaw   <= tick_held.fb_yaw;
                    tick_ch.feedback_pitch <= tick_held.fb_pitch;
                    tick_ch.point_seen     <= tick_held.seen;
                    tick_ch.point_age_ms   <= tick_held.age;
                    tick_ch.object_x       <= tick_held.off_x;
                    tick_ch.object_y       <= tick_held.off_y;
                    if (idle_on && $urandom_range(0, 5) == 0)
                        send_gap = $urandom_range(1, 4);
                end
                else
                    tick_ch.valid <= 1'b0;
            end
        end
    end

    // Command monitor: compare each accepted command with the oldest
    // prediction, and stall the block in random bursts while idling is on.
    always @(posedge clk or negedge rst_n)
    begin
        cmd_t want;
        if (!rst_n)
        begin
            cmd_ch.ready <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (cmd_ch.valid && cmd_ch.ready)
            begin
                if (cmd_expected.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: command with no tick pending, expected none, got yaw %0d pitch %0d",
                             $time, cmd_ch.yaw_target, cmd_ch.pitch_target);
                end
                else
                begin
                    want = cmd_expected.pop_front();
                    if (cmd_ch.yaw_target !== want.yaw)
                        flag_mismatch("yaw_target", want.yaw, cmd_ch.yaw_target);
                    if (cmd_ch.pitch_target !== want.pitch)
                        flag_mismatch("pitch_target", want.pitch, cmd_ch.pitch_target);
                    if (cmd_ch.tracking !== want.tracking)
                        flag_mismatch("tracking", want.tracking, cmd_ch.tracking);
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                cmd_ch.ready <= 1'b0;
            end
            else
            begin
                cmd_ch.ready <= 1'b1;
                if (idle_on && $urandom_range(0, 5) == 0)
                    stall_left = $urandom_range(1, 4);
            end
        end
    end

    // Watchdog: a hung handshake ends the run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb_top failed");
            $finish;
        end
    end

    initial
    begin
        int p;
        int n;

        // Every input known from time zero.
        clk                    = 1'b0;
        rst_n                  = 1'b0;
        cfg_we                 = 1'b0;
        cfg_index              = '0;
        cfg_wdata              = '0;
        tick_ch.valid          = 1'b0;
        tick_ch.feedback_valid = 1'b0;
        tick_ch.feedback_yaw   = '0;
        tick_ch.feedback_pitch = '0;
        tick_ch.point_seen     = 1'b0;
        tick_ch.point_age_ms   = '0;
        tick_ch.object_x       = '0;
        tick_ch.object_y       = '0;
        cmd_ch.ready           = 1'b0;
        mismatches             = 0;
        idle_on                = 1'b1;

        deadband_q    = RST_DEADBAND;
        gain_q        = RST_GAIN;
        step_q        = RST_STEP;
        yaw_hi        = RST_YAW_MAX;
        yaw_lo        = RST_YAW_MIN;
        pitch_hi      = RST_PITCH_MAX;
        pitch_lo      = RST_PITCH_MIN;
        timeout_ms    = RST_TIMEOUT;
        angles_loaded = 1'b0;
        yaw_cmd       = 0;
        pitch_cmd     = 0;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Directed ticks under the reset settings.
        // No feedback before the first load: dropped, state untouched.
        add_tick(make_tick(0, 1000, -1000, 1, 0, 65536, 65536));
        // First feedback loads out-of-range angles; homing then clamps them.
        add_tick(make_tick(1, 262143, -262144, 0, 0, 0, 0));
        // Fresh at one below the timeout; stale exactly at it.
        add_tick(make_tick(1, 0, 0, 1, RST_TIMEOUT - 1, 65536, -65536));
        add_tick(make_tick(1, 0, 0, 1, RST_TIMEOUT, 65536, 65536));
        // Detection never seen, even with age zero.
        add_tick(make_tick(1, 0, 0, 0, 0, 65536, 65536));
        // Offsets exactly on the deadband hold; one past it moves.
        add_tick(make_tick(1, 0, 0, 1, 0, RST_DEADBAND, -RST_DEADBAND));
        add_tick(make_tick(1, 0, 0, 1, 0, RST_DEADBAND + 1, -RST_DEADBAND - 1));
        // Offset field extremes, both signs.
        add_tick(make_tick(1, 0, 0, 1, 0, 131071, -131072));
        add_tick(make_tick(1, 0, 0, 1, 0, -131072, 131071));
        add_tick(make_tick(1, 0, 0, 1, 0, -65536, 65536));
        // Dropped tick carrying every field at its extreme.
        add_tick(make_tick(0, -262144, 262143, 1, 1048575, -131072, 131071));
        // Saturated age: homing.
        add_tick(make_tick(1, 0, 0, 1, 1048575, 0, 0));
        // A run of homing ticks, then tracking resumes.
        for (n = 0; n < 6; n++)
            add_tick(make_tick(1, 0, 0, 0, 0, 131071, 131071));
        add_tick(make_tick(1, 0, 0, 1, 1, -3278, 3278));
        add_tick(make_tick(1, 0, 0, 1, 0, 0, 0));

        for (n = 0; n < RANDOM_TICKS; n++)
            add_tick(random_tick());

        // Later phases: reconfigure only once the pipe is empty.
        for (p = 1; p <= LAST_PHASE; p++)
        begin
            wait_drained();
            case (p)
                // Widest swing: no deadband, maximum gain, no homing, full limits.
                1: set_all(0, 131071, 0, 262143, -262144, 262143, -262144, 1048575);
                // Nothing ever fresh, home snaps in one step, tight limits.
                2: set_all(131071, 65536, 131071, 20000, -20000, 10000, -10000, 0);
                // Crossed limits on both axes; half gain gives rounding ties.
                3: set_all(1000, 32768, 100, -1000, 1000, -50000, 50000, 500);
                4: set_all(RST_DEADBAND, RST_GAIN, RST_STEP, RST_YAW_MAX, RST_YAW_MIN,
                           RST_PITCH_MAX, RST_PITCH_MIN, RST_TIMEOUT);
                // Raw register words over the full port width.
                10: set_all($urandom, $urandom, $urandom, $urandom, $urandom,
                            $urandom, $urandom, $urandom);
                // Final stretch runs at full rate, no idling on either side.
                LAST_PHASE:
                begin
                    idle_on = 1'b0;
                    set_all(RST_DEADBAND, RST_GAIN, RST_STEP, RST_YAW_MAX, RST_YAW_MIN,
                            RST_PITCH_MAX, RST_PITCH_MIN, RST_TIMEOUT);
                end
                default:
                    set_all($urandom_range(0, 65536), $urandom_range(0, 65536),
                            $urandom_range(0, 8000),
                            $urandom_range(0, 205887), -longint'($urandom_range(0, 205887)),
                            random_angle(), random_angle(), $urandom_range(0, 5000));
            endcase
            for (n = 0; n < RANDOM_TICKS; n++)
                add_tick(random_tick());
        end

        wait_drained();
        if (mismatches == 0 && cmd_expected.size() == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule

// File: sim.f
+incdir+sv
sv/pttc_pkg.sv
sv/pttc_if.sv
sv/pan_tilt_tracking_controller.sv
sv/pttc_checker.sv
bench/tb_top.sv
